// ===== rtl/core/dipolar_pair_sum_defines.svh =====
// Assertion macros for the dipolar pair sum block.
// Used by the top level only; relies on signals clk and rst in scope.
`ifndef DIPOLAR_PAIR_SUM_DEFINES_SVH
`define DIPOLAR_PAIR_SUM_DEFINES_SVH

// check a condition at every clock edge outside reset
`define DPS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check an implication at every clock edge outside reset
`define DPS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check an implication at every clock edge, reset included
`define DPS_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/dipsum_pkg.sv =====
// Shared widths, queue entry type, back-end state type and fixed point helpers
// for the dipolar pair sum block. No dependencies.
package dipsum_pkg;

  localparam int FRAC_BITS = 24;
  localparam int SPIN_W    = 16;
  localparam int DIST_W    = 24;
  localparam int OUT_W     = 48;
  localparam int SUM_W     = 64;
  localparam int PREF_W    = 32;
  localparam int PREF_FRAC = 24;
  localparam int DOT_W     = 33;
  localparam int RDOT_W    = 18;
  localparam int PP_W      = 36;
  localparam int QE_W      = 34;
  localparam int BR_W      = 39;
  localparam int FB_W      = 37;
  localparam int PROD_W    = 64;
  localparam int SHIFT     = 50 - FRAC_BITS;
  localparam int TERM_W    = PROD_W - SHIFT;
  localparam int MAG_HALF  = 32;
  localparam int R_W       = OUT_W + 1;
  localparam int HI_LIM_B  = OUT_W - 1 - (MAG_HALF - PREF_FRAC);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;
  localparam int NCH       = 4;
  localparam int CH_W      = 2;

  typedef struct packed {
    logic signed [TERM_W-1:0] energy;
    logic signed [TERM_W-1:0] fx;
    logic signed [TERM_W-1:0] fy;
    logic signed [TERM_W-1:0] fz;
    logic                     last;
  } term_t;

  typedef enum logic [2:0] {
    ST_ACC   = 3'b001,
    ST_SCALE = 3'b010,
    ST_HOLD  = 3'b100
  } back_state_t;

  typedef enum logic [1:0] {
    STEP_HI  = 2'd0,
    STEP_LO  = 2'd1,
    STEP_SAT = 2'd2
  } scale_step_t;

  function automatic logic signed [RDOT_W-1:0] round_dot(input logic signed [DOT_W-1:0] v);
    logic signed [DOT_W:0] t;
    logic signed [DOT_W:0] s;
    t = (DOT_W+1)'(v) + (DOT_W+1)'(1 << 14);
    s = t >>> 15;
    return s[RDOT_W-1:0];
  endfunction

  function automatic logic signed [TERM_W-1:0] round_prod(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] s;
    t = v + (PROD_W'(1) <<< (SHIFT - 1));
    s = t >>> SHIFT;
    return s[TERM_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [TERM_W-1:0] t);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W+1-TERM_W){t[TERM_W-1]}}, t};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// ===== rtl/core/dipsum_front.sv =====
// Front end: accepts pair items and computes the rounded energy and field terms
// in a three stage product pipeline. Depends on dipsum_pkg.
module dipsum_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                in_valid,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] center_spin_x,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] center_spin_y,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] center_spin_z,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] neighbor_spin_x,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] neighbor_spin_y,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] neighbor_spin_z,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] unit_vec_x,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] unit_vec_y,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] unit_vec_z,
  input  logic        [dipsum_pkg::DIST_W-1:0] inv_dist_cubed,
  input  logic                                last_pair,
  output logic                                push,
  output dipsum_pkg::term_t                   push_term
);

  logic v1, v2, v3;

  logic signed [dipsum_pkg::DOT_W-1:0]  a1, se1, je1;
  logic signed [dipsum_pkg::SPIN_W-1:0] sj1 [3];
  logic signed [dipsum_pkg::SPIN_W-1:0] e1  [3];
  logic        [dipsum_pkg::DIST_W-1:0] d1;
  logic                                last1;

  logic signed [dipsum_pkg::RDOT_W-1:0] se_r, je_r;
  logic signed [dipsum_pkg::DOT_W-1:0]  a2;
  logic signed [dipsum_pkg::PP_W-1:0]   p2;
  logic signed [dipsum_pkg::QE_W-1:0]   q2  [3];
  logic signed [dipsum_pkg::SPIN_W-1:0] sj2 [3];
  logic        [dipsum_pkg::DIST_W-1:0] d2;
  logic                                last2;

  logic signed [dipsum_pkg::BR_W-1:0]   br;
  logic signed [dipsum_pkg::FB_W-1:0]   fb  [3];
  logic signed [dipsum_pkg::DIST_W:0]   ds;
  logic signed [dipsum_pkg::PROD_W-1:0] ep3;
  logic signed [dipsum_pkg::PROD_W-1:0] fp3 [3];
  logic                                last3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a1  <= dipsum_pkg::DOT_W'(center_spin_x * neighbor_spin_x)
           + dipsum_pkg::DOT_W'(center_spin_y * neighbor_spin_y)
           + dipsum_pkg::DOT_W'(center_spin_z * neighbor_spin_z);
      se1 <= dipsum_pkg::DOT_W'(center_spin_x * unit_vec_x)
           + dipsum_pkg::DOT_W'(center_spin_y * unit_vec_y)
           + dipsum_pkg::DOT_W'(center_spin_z * unit_vec_z);
      je1 <= dipsum_pkg::DOT_W'(neighbor_spin_x * unit_vec_x)
           + dipsum_pkg::DOT_W'(neighbor_spin_y * unit_vec_y)
           + dipsum_pkg::DOT_W'(neighbor_spin_z * unit_vec_z);
      sj1[0] <= neighbor_spin_x;
      sj1[1] <= neighbor_spin_y;
      sj1[2] <= neighbor_spin_z;
      e1[0]  <= unit_vec_x;
      e1[1]  <= unit_vec_y;
      e1[2]  <= unit_vec_z;
      d1     <= inv_dist_cubed;
      last1  <= last_pair;
    end
  end

  assign se_r = dipsum_pkg::round_dot(se1);
  assign je_r = dipsum_pkg::round_dot(je1);

  always_ff @(posedge clk) begin
    if (advance) begin
      a2 <= a1;
      p2 <= dipsum_pkg::PP_W'(se_r * je_r);
      for (int k = 0; k < 3; k++) begin
        q2[k]  <= dipsum_pkg::QE_W'(je_r * e1[k]);
        sj2[k] <= sj1[k];
      end
      d2    <= d1;
      last2 <= last1;
    end
  end

  always_comb begin
    br = dipsum_pkg::BR_W'(a2) - 3 * dipsum_pkg::BR_W'(p2);
    for (int k = 0; k < 3; k++) begin
      fb[k] = dipsum_pkg::FB_W'(sj2[k]) * 32768 - 3 * dipsum_pkg::FB_W'(q2[k]);
    end
    ds = $signed({1'b0, d2});
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ep3 <= dipsum_pkg::PROD_W'(br * ds);
      for (int k = 0; k < 3; k++) begin
        fp3[k] <= dipsum_pkg::PROD_W'(fb[k] * ds);
      end
      last3 <= last2;
    end
  end

  assign push             = v3 && advance;
  assign push_term.energy = dipsum_pkg::round_prod(ep3);
  assign push_term.fx     = dipsum_pkg::round_prod(fp3[0]);
  assign push_term.fy     = dipsum_pkg::round_prod(fp3[1]);
  assign push_term.fz     = dipsum_pkg::round_prod(fp3[2]);
  assign push_term.last   = last3;

endmodule

// ===== rtl/core/dipsum_queue.sv =====
// Short term queue between front and back end of the dipolar pair sum block.
// Depends on dipsum_pkg.
module dipsum_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  dipsum_pkg::term_t               wdata,
  input  logic                            pop,
  output dipsum_pkg::term_t               rdata,
  output logic [dipsum_pkg::QCNT_W-1:0]   count,
  output logic                            full,
  output logic                            empty
);

  dipsum_pkg::term_t mem [dipsum_pkg::QDEPTH];
  logic [dipsum_pkg::QPTR_W-1:0] head, tail;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + dipsum_pkg::QCNT_W'(push) - dipsum_pkg::QCNT_W'(pop);
    end
  end

  assign rdata = mem[head];
  assign full  = (count == dipsum_pkg::QCNT_W'(dipsum_pkg::QDEPTH));
  assign empty = (count == '0);

endmodule

// ===== rtl/core/dipsum_back.sv =====
// Back end: saturating accumulation of pair terms and output scaling through
// 32x32 products of each sum magnitude. Depends on dipsum_pkg.
module dipsum_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [dipsum_pkg::PREF_W-1:0]        prefactor,
  input  logic                                 q_empty,
  input  dipsum_pkg::term_t                    q_term,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dipsum_pkg::OUT_W-1:0]  energy,
  output logic signed [dipsum_pkg::OUT_W-1:0]  field_x,
  output logic signed [dipsum_pkg::OUT_W-1:0]  field_y,
  output logic signed [dipsum_pkg::OUT_W-1:0]  field_z
);

  localparam logic [dipsum_pkg::R_W-1:0] LIM = dipsum_pkg::R_W'(1) << (dipsum_pkg::OUT_W - 1);

  dipsum_pkg::back_state_t state;
  dipsum_pkg::scale_step_t step;
  logic [dipsum_pkg::CH_W-1:0] ch;

  logic signed [dipsum_pkg::SUM_W-1:0] sum  [dipsum_pkg::NCH];
  logic signed [dipsum_pkg::SUM_W-1:0] snap [dipsum_pkg::NCH];
  logic signed [dipsum_pkg::SUM_W-1:0] sum_next [dipsum_pkg::NCH];
  logic signed [dipsum_pkg::OUT_W-1:0] res  [dipsum_pkg::NCH];

  logic [dipsum_pkg::SUM_W-1:0]    sel, mag;
  logic                            sel_neg;
  logic [dipsum_pkg::SUM_W-1:0]    hi_prod, lo_prod;
  logic [dipsum_pkg::MAG_HALF-1:0] mag_lo;
  logic                            neg_r;
  logic [dipsum_pkg::R_W-1:0]      r, rr;
  logic [dipsum_pkg::R_W-1:0]      neg_rr;
  logic signed [dipsum_pkg::OUT_W-1:0] res_val;
  logic                            out_free;

  assign pop      = (state == dipsum_pkg::ST_ACC) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sum_next[0] = dipsum_pkg::sat_add(sum[0], q_term.energy);
    sum_next[1] = dipsum_pkg::sat_add(sum[1], q_term.fx);
    sum_next[2] = dipsum_pkg::sat_add(sum[2], q_term.fy);
    sum_next[3] = dipsum_pkg::sat_add(sum[3], q_term.fz);
  end

  always_comb begin
    sel     = snap[ch];
    sel_neg = sel[dipsum_pkg::SUM_W-1];
    mag     = sel_neg ? (dipsum_pkg::SUM_W'(0) - sel) : sel;
    if (hi_prod >= (dipsum_pkg::SUM_W'(1) << dipsum_pkg::HI_LIM_B)) begin
      r = LIM;
    end else begin
      r = dipsum_pkg::R_W'(hi_prod << (dipsum_pkg::MAG_HALF - dipsum_pkg::PREF_FRAC))
        + dipsum_pkg::R_W'(lo_prod >> dipsum_pkg::PREF_FRAC);
    end
    if (neg_r) begin
      rr      = (r > LIM) ? LIM : r;
      neg_rr  = dipsum_pkg::R_W'(0) - rr;
      res_val = neg_rr[dipsum_pkg::OUT_W-1:0];
    end else begin
      rr      = (r > LIM - 1'b1) ? LIM - 1'b1 : r;
      neg_rr  = rr;
      res_val = rr[dipsum_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dipsum_pkg::ST_ACC;
      step      <= dipsum_pkg::STEP_HI;
      ch        <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < dipsum_pkg::NCH; k++) begin
        sum[k] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != dipsum_pkg::ST_HOLD) begin
        out_valid <= 1'b0;
      end
      case (state)
        dipsum_pkg::ST_ACC: begin
          if (pop) begin
            if (q_term.last) begin
              for (int k = 0; k < dipsum_pkg::NCH; k++) begin
                snap[k] <= sum_next[k];
                sum[k]  <= '0;
              end
              ch    <= '0;
              step  <= dipsum_pkg::STEP_HI;
              state <= dipsum_pkg::ST_SCALE;
            end else begin
              for (int k = 0; k < dipsum_pkg::NCH; k++) begin
                sum[k] <= sum_next[k];
              end
            end
          end
        end
        dipsum_pkg::ST_SCALE: begin
          case (step)
            dipsum_pkg::STEP_HI: begin
              hi_prod <= dipsum_pkg::SUM_W'(mag[dipsum_pkg::SUM_W-1:dipsum_pkg::MAG_HALF])
                       * dipsum_pkg::SUM_W'(prefactor);
              mag_lo  <= mag[dipsum_pkg::MAG_HALF-1:0];
              neg_r   <= sel_neg ^ (ch != '0);
              step    <= dipsum_pkg::STEP_LO;
            end
            dipsum_pkg::STEP_LO: begin
              lo_prod <= dipsum_pkg::SUM_W'(mag_lo) * dipsum_pkg::SUM_W'(prefactor)
                       + (dipsum_pkg::SUM_W'(1) << (dipsum_pkg::PREF_FRAC - 1));
              step    <= dipsum_pkg::STEP_SAT;
            end
            dipsum_pkg::STEP_SAT: begin
              res[ch] <= res_val;
              step    <= dipsum_pkg::STEP_HI;
              if (ch == dipsum_pkg::CH_W'(dipsum_pkg::NCH - 1)) begin
                state <= dipsum_pkg::ST_HOLD;
              end else begin
                ch <= ch + 1'b1;
              end
            end
            default: begin
              step <= dipsum_pkg::STEP_HI;
            end
          endcase
        end
        dipsum_pkg::ST_HOLD: begin
          if (out_free) begin
            energy    <= res[0];
            field_x   <= res[1];
            field_y   <= res[2];
            field_z   <= res[3];
            out_valid <= 1'b1;
            state     <= dipsum_pkg::ST_ACC;
          end
        end
        default: begin
          state <= dipsum_pkg::ST_ACC;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/dipolar_pair_sum.sv =====
// Top level of the dipolar pair sum block: prefactor register, front end,
// term queue and back end. Depends on dipsum_pkg and dipolar_pair_sum_defines.svh.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   spins, unit vector, inv cube, last flag
//   out      output     out_valid / out_stall energy, field_x/y/z
//   cfg      input      cfg_valid / cfg_ready prefactor (cfg_data)
//
// An item is taken every cycle while the four entry term queue has room; the
// front product pipeline fills the queue and the back end adds one item a cycle
// while accumulating. An item marked last starts scaling on 32x32 products of
// each sum, then loads the output register. Synchronous reset clears sums,
// queue and output valid; out_stall holds the result and can stall the back end.
`include "dipolar_pair_sum_defines.svh"
module dipolar_pair_sum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] center_spin_x,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] center_spin_y,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] center_spin_z,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] neighbor_spin_x,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] neighbor_spin_y,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] neighbor_spin_z,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] unit_vec_x,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] unit_vec_y,
  input  logic signed [dipsum_pkg::SPIN_W-1:0] unit_vec_z,
  input  logic        [dipsum_pkg::DIST_W-1:0] inv_dist_cubed,
  input  logic                                 last_pair,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dipsum_pkg::OUT_W-1:0]  energy,
  output logic signed [dipsum_pkg::OUT_W-1:0]  field_x,
  output logic signed [dipsum_pkg::OUT_W-1:0]  field_y,
  output logic signed [dipsum_pkg::OUT_W-1:0]  field_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dipsum_pkg::PREF_W-1:0]        cfg_data
);

  logic [dipsum_pkg::PREF_W-1:0] prefactor;
  logic                          advance;
  logic                          push, pop;
  dipsum_pkg::term_t             push_term, q_term;
  logic [dipsum_pkg::QCNT_W-1:0] q_count;
  logic                          q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign advance   = !q_full;
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefactor <= '0;
    end else if (cfg_valid && cfg_ready) begin
      prefactor <= cfg_data;
    end
  end

  dipsum_front u_front (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .in_valid        (in_valid),
    .center_spin_x   (center_spin_x),
    .center_spin_y   (center_spin_y),
    .center_spin_z   (center_spin_z),
    .neighbor_spin_x (neighbor_spin_x),
    .neighbor_spin_y (neighbor_spin_y),
    .neighbor_spin_z (neighbor_spin_z),
    .unit_vec_x      (unit_vec_x),
    .unit_vec_y      (unit_vec_y),
    .unit_vec_z      (unit_vec_z),
    .inv_dist_cubed  (inv_dist_cubed),
    .last_pair       (last_pair),
    .push            (push),
    .push_term       (push_term)
  );

  dipsum_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_term),
    .pop   (pop),
    .rdata (q_term),
    .count (q_count),
    .full  (q_full),
    .empty (q_empty)
  );

  dipsum_back u_back (
    .clk       (clk),
    .rst       (rst),
    .prefactor (prefactor),
    .q_empty   (q_empty),
    .q_term    (q_term),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .energy    (energy),
    .field_x   (field_x),
    .field_y   (field_y),
    .field_z   (field_z)
  );

  `DPS_ASSERT(a_queue_bound, q_count <= dipsum_pkg::QCNT_W'(dipsum_pkg::QDEPTH), "queue overfilled")
  `DPS_IMPLIES(a_empty_no_stall, q_count == '0, !in_stall, "stall with empty queue")
  `DPS_ALWAYS(a_reset_clear, $past(rst), !out_valid && q_count == '0, "state not cleared by reset")

endmodule

// ===== verif/tb_dipolar_pair_sum.sv =====
// Self-checking bench for dipolar_pair_sum: directed and random spin pairs grouped into sites,
// results predicted in a scoreboard class and compared field by field.
// Depends on dipsum_pkg and the dipolar_pair_sum RTL.
module tb_dipolar_pair_sum;

  localparam longint SUM_MAX = 64'sh7fffffffffffffff;
  localparam longint SUM_MIN = 64'sh8000000000000000;

  typedef struct {
    logic signed [dipsum_pkg::OUT_W-1:0] energy;
    logic signed [dipsum_pkg::OUT_W-1:0] fx;
    logic signed [dipsum_pkg::OUT_W-1:0] fy;
    logic signed [dipsum_pkg::OUT_W-1:0] fz;
  } site_result_t;

  class site_sum_board;
    logic [31:0] prefactor;
    longint energy_acc;
    longint field_acc[3];
    site_result_t pending[$];
    int errors;

    function new();
      prefactor = 0;
      energy_acc = 0;
      field_acc = '{0, 0, 0};
      errors = 0;
    endfunction

    function longint round_down(longint v, int s);
      longint t;
      t = v + (longint'(1) << (s - 1));
      return t >>> s;
    endfunction

    function longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SUM_MIN : SUM_MAX;
      return s;
    endfunction

    function logic signed [dipsum_pkg::OUT_W-1:0] scale(longint s, bit neg);
      bit n;
      logic [63:0] mag, hi, lo, r, lim;
      n = s < 0;
      mag = n ? -s : s;
      hi = (mag >> 32) * prefactor;
      lo = (mag & 64'hffffffff) * prefactor + (64'd1 << (dipsum_pkg::PREF_FRAC - 1));
      lim = 64'd1 << (dipsum_pkg::OUT_W - 1);
      if (neg) n = !n;
      if (hi >= (64'd1 << (dipsum_pkg::OUT_W - 1 - (32 - dipsum_pkg::PREF_FRAC)))) r = lim;
      else r = (hi << (32 - dipsum_pkg::PREF_FRAC)) + (lo >> dipsum_pkg::PREF_FRAC);
      if (n) begin
        if (r > lim) r = lim;
        r = -r;
        return r[dipsum_pkg::OUT_W-1:0];
      end
      if (r > lim - 1) r = lim - 1;
      return r[dipsum_pkg::OUT_W-1:0];
    endfunction

    function void note_pair(logic signed [15:0] ci[3], logic signed [15:0] nj[3],
                            logic signed [15:0] ev[3], logic [23:0] d, bit last);
      longint a, se, je, br, fb;
      site_result_t r;
      a = 0; se = 0; je = 0;
      for (int k = 0; k < 3; k++) begin
        a += longint'(ci[k]) * nj[k];
        se += longint'(ci[k]) * ev[k];
        je += longint'(nj[k]) * ev[k];
      end
      se = round_down(se, 15);
      je = round_down(je, 15);
      br = a - 3 * se * je;
      energy_acc = add_sat(energy_acc,
                           round_down(br * longint'(d), 50 - dipsum_pkg::FRAC_BITS));
      for (int k = 0; k < 3; k++) begin
        fb = longint'(nj[k]) * 32768 - 3 * je * ev[k];
        field_acc[k] = add_sat(field_acc[k],
                               round_down(fb * longint'(d), 50 - dipsum_pkg::FRAC_BITS));
      end
      if (!last) return;
      r.energy = scale(energy_acc, 0);
      r.fx = scale(field_acc[0], 1);
      r.fy = scale(field_acc[1], 1);
      r.fz = scale(field_acc[2], 1);
      pending.push_back(r);
      energy_acc = 0;
      field_acc = '{0, 0, 0};
    endfunction

    function void check_site(site_result_t got);
      site_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result energy %0d", $time, got.energy);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.energy !== want.energy) begin
        $display("%0t: energy expected %0d actual %0d", $time, want.energy, got.energy);
        errors++;
      end
      if (got.fx !== want.fx) begin
        $display("%0t: field_x expected %0d actual %0d", $time, want.fx, got.fx);
        errors++;
      end
      if (got.fy !== want.fy) begin
        $display("%0t: field_y expected %0d actual %0d", $time, want.fy, got.fy);
        errors++;
      end
      if (got.fz !== want.fz) begin
        $display("%0t: field_z expected %0d actual %0d", $time, want.fz, got.fz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [15:0] cx = 0, cy = 0, cz = 0, nx = 0, ny = 0, nz = 0, ux = 0, uy = 0, uz = 0;
  logic [23:0] inv_cube = 0;
  logic last = 0;
  logic signed [dipsum_pkg::OUT_W-1:0] energy, field_x, field_y, field_z;
  logic cfg_valid = 0, cfg_ready;
  logic [31:0] cfg_data = 0;
  int send_idle = 0, recv_idle = 0;

  site_sum_board board = new();

  always #5 clk = ~clk;

  dipolar_pair_sum dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .center_spin_x(cx), .center_spin_y(cy), .center_spin_z(cz),
    .neighbor_spin_x(nx), .neighbor_spin_y(ny), .neighbor_spin_z(nz),
    .unit_vec_x(ux), .unit_vec_y(uy), .unit_vec_z(uz),
    .inv_dist_cubed(inv_cube), .last_pair(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .energy(energy), .field_x(field_x), .field_y(field_y), .field_z(field_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    site_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.energy = energy; got.fx = field_x; got.fy = field_y; got.fz = field_z;
      board.check_site(got);
    end
  end

  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < recv_idle);

  task automatic send_pair(logic signed [15:0] ci[3], logic signed [15:0] nj[3],
                           logic signed [15:0] ev[3], logic [23:0] d, bit lp);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    cx <= ci[0]; cy <= ci[1]; cz <= ci[2];
    nx <= nj[0]; ny <= nj[1]; nz <= nj[2];
    ux <= ev[0]; uy <= ev[1]; uz <= ev[2];
    inv_cube <= d; last <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pair(ci, nj, ev, d, lp);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(bit lp, int pick);
    logic signed [15:0] ci[3], nj[3], ev[3];
    logic [23:0] d;
    for (int k = 0; k < 3; k++) begin
      ci[k] = rand_comp(pick ? $urandom_range(3) : 3);
      nj[k] = rand_comp(pick ? $urandom_range(3) : 3);
      ev[k] = rand_comp(pick ? $urandom_range(3) : 3);
    end
    case ($urandom_range(3))
      0: d = 24'hffffff;
      1: d = 24'($urandom_range(255));
      default: d = 24'($urandom);
    endcase
    send_pair(ci, nj, ev, d, lp);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_prefactor(logic [31:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.prefactor = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic run_sites(int pairs);
    int n;
    n = 0;
    while (n < pairs) begin
      int len;
      len = $urandom_range(9) == 0 ? $urandom_range(40, 20) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        send_random(i == len - 1, $urandom_range(3) == 0);
        n++;
      end
    end
  endtask

  initial begin
    logic signed [15:0] pmax[3], pmin[3], zero3[3];
    pmax = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
    pmin = '{16'sh8000, 16'sh8000, 16'sh8000};
    zero3 = '{0, 0, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    write_prefactor(32'h0100_0000);
    send_pair(pmax, pmax, pmax, 24'hffffff, 1);
    send_pair(pmin, pmin, pmin, 24'hffffff, 1);
    send_pair(pmax, pmin, pmax, 24'hffffff, 0);
    send_pair(pmin, pmax, pmin, 0, 1);
    send_pair(zero3, zero3, zero3, 24'hffffff, 1);
    send_pair(pmax, pmin, zero3, 24'h000001, 1);
    for (int i = 0; i < 8; i++) send_random(i % 3 == 2, 1);
    drain();
    write_prefactor(32'hffffffff);
    for (int i = 0; i < 200; i++) send_pair(pmin, pmax, pmin, 24'hffffff, i == 199);
    send_pair(pmax, pmax, zero3, 24'hffffff, 1);
    drain();
    write_prefactor(0);
    send_random(1, 1);
    drain();
    write_prefactor($urandom);
    send_idle = 37; recv_idle = 53;
    run_sites(160);
    drain();
    write_prefactor($urandom_range(32'h0400_0000));
    send_idle = 53; recv_idle = 37;
    run_sites(160);
    drain();
    write_prefactor(32'h0100_0000);
    send_idle = 0; recv_idle = 0;
    run_sites(160);
    drain();
    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dipsum_pkg.sv
rtl/core/dipsum_front.sv
rtl/core/dipsum_queue.sv
rtl/core/dipsum_back.sv
rtl/core/dipolar_pair_sum.sv
verif/tb_dipolar_pair_sum.sv
